// File: sv/b64enc_pkg.sv
`timescale 1ns / 1ps

package b64enc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last_of_group;
        logic       message_end;
    } out_item_t;

    // One closed group of up to three bytes; missing bytes are zero-filled.
    typedef struct packed {
        logic [23:0] group_bytes;
        logic [1:0]  pad_count;
        logic        msg_final;
    } group_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } link_t;

    function automatic logic [7:0] b64_char(input logic [5:0] sextet);
        logic [7:0] code;
        code = {2'b00, sextet};
        priority if (sextet < 6'd26)
            return 8'd65 + code;
        else if (sextet < 6'd52)
            return 8'd71 + code;
        else if (sextet < 6'd62)
            return code - 8'd4;
        else if (sextet == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

endpackage

// File: sv/b64enc_front.sv
`timescale 1ns / 1ps

module b64enc_front
    import b64enc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output link_t    push_link,
    input  logic     push_ready,
    output group_t   push_group
);

    logic [15:0] pending_bytes_reg;
    logic [15:0] pending_bytes_next;
    logic [1:0]  pending_count_reg;
    logic [1:0]  pending_count_next;
    logic [1:0]  count_eff;
    logic        accept;
    logic        closes;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    // A count of three cannot occur; it is folded back to an empty group.
    assign count_eff = (pending_count_reg == 2'd3) ? 2'd0 : pending_count_reg;
    assign closes    = in_item.final_byte || (count_eff == 2'd2);

    assign push_link.valid = accept && closes;
    assign push_link.ready = push_ready;

    always_comb
    begin
        push_group.msg_final = in_item.final_byte;
        unique case (count_eff)
            2'd0:
            begin
                push_group.group_bytes = {in_item.data_byte, 16'h0000};
                push_group.pad_count   = 2'd2;
            end
            2'd1:
            begin
                push_group.group_bytes = {pending_bytes_reg[15:8], in_item.data_byte, 8'h00};
                push_group.pad_count   = 2'd1;
            end
            default:
            begin
                push_group.group_bytes = {pending_bytes_reg, in_item.data_byte};
                push_group.pad_count   = 2'd0;
            end
        endcase
    end

    always_comb
    begin
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        if (accept)
        begin
            if (closes)
            begin
                pending_bytes_next = 16'h0000;
                pending_count_next = 2'd0;
            end
            else if (count_eff == 2'd0)
            begin
                pending_bytes_next = {in_item.data_byte, 8'h00};
                pending_count_next = 2'd1;
            end
            else
            begin
                pending_bytes_next = {pending_bytes_reg[15:8], in_item.data_byte};
                pending_count_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes_reg <= 16'h0000;
            pending_count_reg <= 2'd0;
        end
        else
        begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

// File: sv/b64enc_queue.sv
`timescale 1ns / 1ps

module b64enc_queue
    import b64enc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  group_t push_group,
    output link_t  pop_link,
    input  logic   pop_ready,
    output group_t pop_group
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    group_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready     = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_link.valid = (count_reg != '0);
    assign pop_link.ready = pop_ready;
    assign pop_group      = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_link.valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_group;
    end

endmodule

// File: sv/b64enc_back.sv
`timescale 1ns / 1ps

module b64enc_back
    import b64enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      grp_valid,
    output logic      grp_pop,
    input  group_t    grp,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic [1:0] char_idx_reg;
    logic [1:0] char_idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;
    logic       advance;
    logic       load;
    logic [5:0] sextet;
    logic       is_pad;

    assign advance = !out_valid_reg || out_ready;
    assign load    = advance && grp_valid;
    assign grp_pop = load && (char_idx_reg == 2'd3);

    always_comb
    begin
        unique case (char_idx_reg)
            2'd0:    sextet = grp.group_bytes[23:18];
            2'd1:    sextet = grp.group_bytes[17:12];
            2'd2:    sextet = grp.group_bytes[11:6];
            default: sextet = grp.group_bytes[5:0];
        endcase
    end

    // Padding fills the tail of the group: index 4 - pad_count and above.
    assign is_pad = ({1'b0, char_idx_reg} + {1'b0, grp.pad_count}) > 3'd3;

    always_comb
    begin
        char_idx_next  = char_idx_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (load)
        begin
            char_idx_next               = char_idx_reg + 2'd1;
            out_valid_next              = 1'b1;
            out_item_next.ascii_char    = is_pad ? PAD_CHAR : b64_char(sextet);
            out_item_next.last_of_group = (char_idx_reg == 2'd3);
            out_item_next.message_end   = (char_idx_reg == 2'd3) && grp.msg_final;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_idx_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            char_idx_reg  <= char_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: sv/base64_stream_encoder_top.sv
`timescale 1ns / 1ps
// Channel | Signals                          | Moves
// input   | in_valid, in_ready, in_item      | one message byte and its final flag
// output  | out_valid, out_ready, out_item   | one ASCII character with group/end flags
//
// The front packs bytes and takes one byte per cycle while the two-entry group
// queue has room; a closed group enters the queue in the cycle its last byte does.
// The back emits one character per cycle while out_ready does not stall it, from the queue
// head through the output register, so a group yields four characters.
// Reset clears the pending byte count, the queue pointers and the output valid.
// A stalled output holds its character; the front stalls only when the queue is full.

module base64_stream_encoder_top
    import b64enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    link_t  push_link;
    link_t  pop_link;
    group_t push_group;
    group_t pop_group;
    logic   q_push_ready;
    logic   q_pop;

    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_link  (push_link),
        .push_ready (q_push_ready),
        .push_group (push_group)
    );

    b64enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_link.valid),
        .push_ready (q_push_ready),
        .push_group (push_group),
        .pop_link   (pop_link),
        .pop_ready  (q_pop),
        .pop_group  (pop_group)
    );

    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (pop_link.valid),
        .grp_pop   (q_pop),
        .grp       (pop_group),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // A final byte always closes a group, so it must be pushed in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.final_byte) |-> push_link.valid)
    else $error("final byte accepted without pushing a group");

    // Retiring a queue entry means its fourth character was just loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && pop_link.valid) |=> (out_valid && out_item.last_of_group))
    else $error("group retired without a last character");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.message_end) |-> out_item.last_of_group)
    else $error("message end on a character that does not close a group");

    // The input side only stalls because the group queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == push_link.ready)
    else $error("input ready does not follow queue space");

endmodule
